### sv/vals_pkg.sv
// Package: shared types, constants and slot helpers for the VLIW ASAP list scheduler.
package vals_pkg;

    localparam int MAX_INSTR = 256;
    localparam int ID_W      = $clog2(MAX_INSTR);
    localparam int MAX_CYC   = 512;
    localparam int CYC_W     = $clog2(MAX_CYC);
    localparam int RDY_W     = CYC_W + 1;
    localparam int MAX_II    = 64;
    localparam int ROW_W     = $clog2(MAX_II);
    localparam int II_W      = 7;
    localparam int NUM_DEPS  = 4;
    localparam int K_W       = $clog2(NUM_DEPS + 1);
    localparam int SLOT_W    = 3;
    localparam int NSLOT     = 5;

    localparam logic [RDY_W-1:0] LAT_MUL   = RDY_W'(3);
    localparam logic [RDY_W-1:0] LAT_OTHER = RDY_W'(1);

    localparam logic [1:0] CLS_ALU    = 2'd0;
    localparam logic [1:0] CLS_MUL    = 2'd1;
    localparam logic [1:0] CLS_MEM    = 2'd2;
    localparam logic [1:0] CLS_BRANCH = 2'd3;

    localparam logic [1:0] BLK_LOOP = 2'd1;

    localparam logic [SLOT_W-1:0] SLOT_ALU0   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_ALU1   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MUL    = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_MEM    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_BRANCH = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_NONE   = 3'd5;

    typedef struct packed {
        logic            start_program;
        logic [ID_W-1:0] instr_id;
        logic [1:0]      unit_class;
        logic [1:0]      block_class;
        logic [3:0]      dep_valid;
        logic [ID_W-1:0] dep_id_0;
        logic [ID_W-1:0] dep_id_1;
        logic [ID_W-1:0] dep_id_2;
        logic [ID_W-1:0] dep_id_3;
    } t_req;

    typedef struct packed {
        logic [CYC_W-1:0]  issue_cycle;
        logic [SLOT_W-1:0] slot_index;
        logic              overflow;
    } t_res;

    function automatic logic [NSLOT-1:0] unit_mask(input logic [1:0] cls);
        logic [NSLOT-1:0] m;
        unique case (cls)
            CLS_ALU:    m = 5'b00011;
            CLS_MUL:    m = 5'b00100;
            CLS_MEM:    m = 5'b01000;
            CLS_BRANCH: m = 5'b10000;
            default:    m = 5'b10000;
        endcase
        return m;
    endfunction

    function automatic logic [SLOT_W-1:0] free_slot(input logic [NSLOT-1:0] busy,
                                                     input logic [NSLOT-1:0] need);
        logic [NSLOT-1:0] avail;
        logic [SLOT_W-1:0] s;
        avail = need & ~busy;
        priority if (avail[0]) s = SLOT_ALU0;
        else if (avail[1])     s = SLOT_ALU1;
        else if (avail[2])     s = SLOT_MUL;
        else if (avail[3])     s = SLOT_MEM;
        else if (avail[4])     s = SLOT_BRANCH;
        else                   s = SLOT_NONE;
        return s;
    endfunction

    function automatic logic [NSLOT-1:0] slot_bit(input logic [SLOT_W-1:0] s);
        logic [NSLOT-1:0] b;
        unique case (s)
            SLOT_ALU0:   b = 5'b00001;
            SLOT_ALU1:   b = 5'b00010;
            SLOT_MUL:    b = 5'b00100;
            SLOT_MEM:    b = 5'b01000;
            SLOT_BRANCH: b = 5'b10000;
            default:     b = 5'b00000;
        endcase
        return b;
    endfunction

endpackage

### sv/vals_sub.sv
// Shared subtract-and-compare unit used for the producer maximum and the modulo steps.
module vals_sub
    import vals_pkg::*;
(
    input  logic [RDY_W-1:0] i_a,
    input  logic [RDY_W-1:0] i_b,
    output logic [RDY_W-1:0] o_diff,
    output logic             o_ge
);

    logic [RDY_W:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[RDY_W-1:0];
    assign o_ge   = ~w_full[RDY_W];

endmodule

### sv/vliw_asap_list_scheduler.sv
// Top level: sequencer, scheduling tables and result register of the VLIW ASAP list scheduler.
//
//  Channel   Ports                       Transfer
//  request   start, busy, i_req          taken when start is high and busy is low
//  result    o_done, o_res               o_done high for one cycle per request
//  config    i_cfg_we, i_cfg_wdata       written on any edge with i_cfg_we high
//
// A request first gathers its producers, then works out the modulo row in the loop
// body, then probes bundle cycles in turn from the earliest; the result is registered.
// A request with start_program set first sweeps the bundle table.
// After reset the same sweep runs with busy high.
// The receiver cannot stall: each result is valid for its single strobe cycle.
module vliw_asap_list_scheduler
    import vals_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_req            i_req,
    input  logic            i_cfg_we,
    input  logic [II_W-1:0] i_cfg_wdata,
    output logic            o_done,
    output t_res            o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DEP,
        S_MOD,
        S_PROBE
    } t_state;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_res   r_res, n_res;
    logic                 r_done, n_done;
    logic                 r_clr_item, n_clr_item;
    logic [CYC_W-1:0]     r_clr, n_clr;
    logic [K_W-1:0]       r_k, n_k;
    logic                 r_dep_ok, n_dep_ok;
    logic [RDY_W-1:0]     r_earliest, n_earliest;
    logic [3:0]           r_bit, n_bit;
    logic [ROW_W-1:0]     r_rem, n_rem;
    logic [CYC_W-1:0]     r_cyc, n_cyc;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [MAX_INSTR-1:0] r_mark, n_mark;
    logic [II_W-1:0]      r_ii, n_ii;

    logic [RDY_W-1:0] m_ready [MAX_INSTR];
    logic [NSLOT-1:0] m_bundle [MAX_CYC];
    logic [NSLOT-1:0] m_modulo [MAX_II];
    logic [RDY_W-1:0] r_rdy_q;
    logic [NSLOT-1:0] r_bnd_q;
    logic [NSLOT-1:0] r_mod_q;

    logic             w_rdy_we;
    logic [RDY_W-1:0] w_rdy_wdata;
    logic [ID_W-1:0]  w_rdy_raddr;
    logic             w_bnd_we;
    logic [CYC_W-1:0] w_bnd_waddr;
    logic [NSLOT-1:0] w_bnd_wdata;
    logic             w_mod_we;
    logic [ROW_W-1:0] w_mod_waddr;
    logic [NSLOT-1:0] w_mod_wdata;

    logic [RDY_W-1:0]  w_ua, w_ub, w_udiff;
    logic              w_uge;
    logic [II_W-1:0]   w_ii_eff;
    logic [ROW_W:0]    w_shift;
    logic [NSLOT-1:0]  w_need;
    logic [SLOT_W-1:0] w_s, w_m;
    logic              w_loop, w_hit;
    logic [RDY_W-1:0]  w_lat;

    vals_sub u_sub (
        .i_a    (w_ua),
        .i_b    (w_ub),
        .o_diff (w_udiff),
        .o_ge   (w_uge)
    );

    function automatic logic [ID_W-1:0] dep_sel(input t_req req, input logic [1:0] k);
        logic [ID_W-1:0] d;
        unique case (k)
            2'd0:    d = req.dep_id_0;
            2'd1:    d = req.dep_id_1;
            2'd2:    d = req.dep_id_2;
            default: d = req.dep_id_3;
        endcase
        return d;
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        if (r_ii == '0) begin
            w_ii_eff = II_W'(1);
        end else if (r_ii > II_W'(MAX_II)) begin
            w_ii_eff = II_W'(MAX_II);
        end else begin
            w_ii_eff = r_ii;
        end
    end

    assign w_shift     = {r_rem, r_cyc[r_bit]};
    assign w_rdy_raddr = dep_sel(r_req, r_k[1:0]);
    assign w_need      = unit_mask(r_req.unit_class);
    assign w_s         = free_slot(r_bnd_q, w_need);
    assign w_m         = free_slot(r_mod_q, w_need);
    assign w_loop      = (r_req.block_class == BLK_LOOP);
    assign w_hit       = (w_s != SLOT_NONE) && (!w_loop || (w_m != SLOT_NONE));
    assign w_lat       = (r_req.unit_class == CLS_MUL) ? LAT_MUL : LAT_OTHER;

    always_comb begin
        if (r_state == S_MOD) begin
            w_ua = RDY_W'(w_shift);
            w_ub = RDY_W'(w_ii_eff);
        end else begin
            w_ua = r_earliest;
            w_ub = r_rdy_q;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_res      = r_res;
        n_done     = 1'b0;
        n_clr_item = r_clr_item;
        n_clr      = r_clr;
        n_k        = r_k;
        n_dep_ok   = r_dep_ok;
        n_earliest = r_earliest;
        n_bit      = r_bit;
        n_rem      = r_rem;
        n_cyc      = r_cyc;
        n_row      = r_row;
        n_mark     = r_mark;
        n_ii       = i_cfg_we ? i_cfg_wdata : r_ii;

        w_rdy_we    = 1'b0;
        w_rdy_wdata = RDY_W'({1'b0, r_cyc}) + w_lat;
        w_bnd_we    = 1'b0;
        w_bnd_waddr = r_cyc;
        w_bnd_wdata = r_bnd_q | slot_bit(w_s);
        w_mod_we    = 1'b0;
        w_mod_waddr = r_row;
        w_mod_wdata = r_mod_q | slot_bit(w_m);

        unique case (r_state)
            S_CLEAR: begin
                w_bnd_we    = 1'b1;
                w_bnd_waddr = r_clr;
                w_bnd_wdata = '0;
                w_mod_we    = 1'b1;
                w_mod_waddr = r_clr[ROW_W-1:0];
                w_mod_wdata = '0;
                n_clr       = r_clr + CYC_W'(1);
                if (r_clr == CYC_W'(MAX_CYC - 1)) begin
                    n_state = r_clr_item ? S_DEP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req      = i_req;
                    n_k        = '0;
                    n_earliest = '0;
                    n_clr      = '0;
                    n_clr_item = i_req.start_program;
                    if (i_req.start_program) begin
                        n_mark  = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_DEP;
                    end
                end
            end
            S_DEP: begin
                n_dep_ok = r_req.dep_valid[r_k[1:0]] & r_mark[w_rdy_raddr];
                if (r_k != '0 && r_dep_ok && !w_uge) begin
                    n_earliest = r_rdy_q;
                end
                n_k = r_k + K_W'(1);
                if (r_k == K_W'(NUM_DEPS)) begin
                    if (n_earliest[CYC_W]) begin
                        n_res   = '{issue_cycle: '0, slot_index: SLOT_ALU0, overflow: 1'b1};
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_cyc = n_earliest[CYC_W-1:0];
                        if (w_loop) begin
                            n_bit   = 4'(CYC_W - 1);
                            n_rem   = '0;
                            n_state = S_MOD;
                        end else begin
                            n_row   = '0;
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_MOD: begin
                n_rem = w_uge ? w_udiff[ROW_W-1:0] : w_shift[ROW_W-1:0];
                if (r_bit == '0) begin
                    n_row   = n_rem;
                    n_state = S_PROBE;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            S_PROBE: begin
                if (w_hit) begin
                    w_bnd_we       = 1'b1;
                    w_mod_we       = w_loop;
                    w_rdy_we       = 1'b1;
                    n_mark[r_req.instr_id] = 1'b1;
                    n_res   = '{issue_cycle: r_cyc, slot_index: w_s, overflow: 1'b0};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_cyc == CYC_W'(MAX_CYC - 1)) begin
                    n_res   = '{issue_cycle: '0, slot_index: SLOT_ALU0, overflow: 1'b1};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cyc = r_cyc + CYC_W'(1);
                    if ((II_W'(r_row) + II_W'(1)) == w_ii_eff) begin
                        n_row = '0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_req      <= '0;
            r_res      <= '0;
            r_done     <= 1'b0;
            r_clr_item <= 1'b0;
            r_clr      <= '0;
            r_k        <= '0;
            r_dep_ok   <= 1'b0;
            r_earliest <= '0;
            r_bit      <= '0;
            r_rem      <= '0;
            r_cyc      <= '0;
            r_row      <= '0;
            r_mark     <= '0;
            r_ii       <= II_W'(1);
        end else begin
            r_state    <= n_state;
            r_req      <= n_req;
            r_res      <= n_res;
            r_done     <= n_done;
            r_clr_item <= n_clr_item;
            r_clr      <= n_clr;
            r_k        <= n_k;
            r_dep_ok   <= n_dep_ok;
            r_earliest <= n_earliest;
            r_bit      <= n_bit;
            r_rem      <= n_rem;
            r_cyc      <= n_cyc;
            r_row      <= n_row;
            r_mark     <= n_mark;
            r_ii       <= n_ii;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_we) begin
            m_ready[r_req.instr_id] <= w_rdy_wdata;
        end
        r_rdy_q <= m_ready[w_rdy_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_bnd_we) begin
            m_bundle[w_bnd_waddr] <= w_bnd_wdata;
        end
        r_bnd_q <= m_bundle[n_cyc];
    end

    always_ff @(posedge i_clk) begin
        if (w_mod_we) begin
            m_modulo[w_mod_waddr] <= w_mod_wdata;
        end
        r_mod_q <= m_modulo[n_row];
    end

endmodule

### tb/sv/tb_top.sv
// Testbench for the VLIW ASAP list scheduler: directed and random requests, checked on each result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vals_pkg::*;

    localparam logic [1:0] BLK_PROLOGUE = 2'd0;
    localparam logic [1:0] BLK_EPILOGUE = 2'd2;
    localparam logic [1:0] BLK_SPARE    = 2'd3;

    localparam int PROG_WELL  = 0;
    localparam int PROG_CHAIN = 1;
    localparam int PROG_NOISE = 2;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned END_WAIT     = 1100;

    class schedule_checker;
        int unsigned    interval_reg;
        int unsigned    ready_cycle [MAX_INSTR];
        bit             placed      [MAX_INSTR];
        bit [NSLOT-1:0] bundle_used [MAX_CYC];
        bit [NSLOT-1:0] row_used    [MAX_II];
        t_res           expected_issues [$];
        int             error_count;

        function new();
            interval_reg = 1;
            error_count  = 0;
            foreach (ready_cycle[i]) ready_cycle[i] = 0;
            clear_program();
        endfunction

        function void clear_program();
            foreach (placed[i]) placed[i] = 1'b0;
            foreach (bundle_used[i]) bundle_used[i] = '0;
            foreach (row_used[i]) row_used[i] = '0;
        endfunction

        function bit [NSLOT-1:0] unit_need(logic [1:0] cls);
            case (cls)
                CLS_ALU: return 5'b00011;
                CLS_MUL: return 5'b00100;
                CLS_MEM: return 5'b01000;
                default: return 5'b10000;
            endcase
        endfunction

        function logic [SLOT_W-1:0] lowest_free(bit [NSLOT-1:0] used, bit [NSLOT-1:0] need);
            for (int s = 0; s < NSLOT; s++)
                if (need[s] && !used[s]) return SLOT_W'(s);
            return SLOT_NONE;
        endfunction

        function t_res predict_issue(t_req r);
            bit [NSLOT-1:0]    need;
            logic [ID_W-1:0]   deps [NUM_DEPS];
            int unsigned       ii;
            int unsigned       earliest;
            int unsigned       row;
            logic [SLOT_W-1:0] s;
            logic [SLOT_W-1:0] m;
            bit                found;
            bit                modulo;
            t_res              res;
            need = unit_need(r.unit_class);
            ii = (interval_reg == 0) ? 1 : (interval_reg > MAX_II) ? MAX_II : interval_reg;
            modulo = (r.block_class == BLK_LOOP);
            deps[0] = r.dep_id_0;
            deps[1] = r.dep_id_1;
            deps[2] = r.dep_id_2;
            deps[3] = r.dep_id_3;
            res.issue_cycle = '0;
            res.slot_index  = SLOT_ALU0;
            res.overflow    = 1'b1;
            found = 1'b0;
            earliest = 0;
            if (r.start_program) clear_program();
            for (int k = 0; k < NUM_DEPS; k++)
                if (r.dep_valid[k] && placed[deps[k]] && ready_cycle[deps[k]] > earliest)
                    earliest = ready_cycle[deps[k]];
            for (int unsigned c = earliest; c < MAX_CYC && !found; c++) begin
                s   = lowest_free(bundle_used[c], need);
                row = c % ii;
                m   = modulo ? lowest_free(row_used[row], need) : SLOT_ALU0;
                if (s != SLOT_NONE && m != SLOT_NONE) begin
                    found = 1'b1;
                    bundle_used[c][s] = 1'b1;
                    if (modulo) row_used[row][m] = 1'b1;
                    ready_cycle[r.instr_id] = c + ((r.unit_class == CLS_MUL) ? LAT_MUL : LAT_OTHER);
                    placed[r.instr_id] = 1'b1;
                    res.issue_cycle = CYC_W'(c);
                    res.slot_index  = s;
                    res.overflow    = 1'b0;
                end
            end
            return res;
        endfunction

        function void note_request(t_req r);
            expected_issues.insert(expected_issues.size(), predict_issue(r));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        task check_issue(t_res got);
            t_res want;
            if (expected_issues.size() == 0) begin
                report_mismatch($sformatf("result with no request outstanding: cycle %0d slot %0d",
                                          got.issue_cycle, got.slot_index));
                return;
            end
            want = expected_issues.pop_front();
            if (got.issue_cycle !== want.issue_cycle)
                report_mismatch($sformatf("issue_cycle %0d, expected %0d",
                                          got.issue_cycle, want.issue_cycle));
            if (got.slot_index !== want.slot_index)
                report_mismatch($sformatf("slot_index %0d, expected %0d",
                                          got.slot_index, want.slot_index));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %0b, expected %0b",
                                          got.overflow, want.overflow));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_req              i_req       = '0;
    logic              i_cfg_we    = 1'b0;
    logic [II_W-1:0]   i_cfg_wdata = '0;
    logic              o_done;
    t_res              o_res;

    schedule_checker   sched_sb = new();
    int unsigned       requests_sent = 0;
    int unsigned       cycle_count   = 0;
    bit                quiet_stretch = 1'b0;

    vliw_asap_list_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sched_sb.check_issue(o_res);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req make_request(bit sp, int id, logic [1:0] cls, logic [1:0] blk,
                                          logic [3:0] valid, int d0, int d1, int d2, int d3);
        t_req r;
        r.start_program = sp;
        r.instr_id      = ID_W'(id);
        r.unit_class    = cls;
        r.block_class   = blk;
        r.dep_valid     = valid;
        r.dep_id_0      = ID_W'(d0);
        r.dep_id_1      = ID_W'(d1);
        r.dep_id_2      = ID_W'(d2);
        r.dep_id_3      = ID_W'(d3);
        return r;
    endfunction

    function automatic int earlier_id(logic [ID_W-1:0] base, int i);
        if (i == 0 || $urandom_range(0, 6) == 0) return $urandom_range(0, MAX_INSTR - 1);
        return (int'(base) + int'($urandom_range(0, i - 1))) % MAX_INSTR;
    endfunction

    function automatic int unsigned pick_interval();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return $urandom_range(1, 4);
        if (roll < 60) return $urandom_range(5, 16);
        if (roll < 70) return MAX_II;
        if (roll < 75) return 0;
        if (roll < 80) return (1 << II_W) - 1;
        if (roll < 90) return $urandom_range(MAX_II + 1, (1 << II_W) - 1);
        return $urandom_range(17, MAX_II - 1);
    endfunction

    task automatic send_request(input t_req r);
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sched_sb.note_request(r);
        requests_sent++;
    endtask

    task automatic hold_off();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        if (quiet_stretch || roll < 60) n = 0;
        else if (roll < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_spaced(input t_req r);
        send_request(r);
        hold_off();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sched_sb.expected_issues.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_interval(input int unsigned v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= II_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sched_sb.interval_reg = v;
    endtask

    task automatic run_directed();
        write_interval(1);
        send_spaced(make_request(1, 0, CLS_ALU, BLK_PROLOGUE, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 1, CLS_ALU, BLK_PROLOGUE, 4'b0001, 0, 0, 0, 0));
        send_spaced(make_request(0, 2, CLS_ALU, BLK_PROLOGUE, 4'b0010, 9, 0, 9, 9));
        send_spaced(make_request(0, 3, CLS_ALU, BLK_PROLOGUE, 4'b0100, 9, 9, 0, 9));
        send_spaced(make_request(0, 4, CLS_MUL, BLK_PROLOGUE, 4'b1000, 0, 0, 0, 1));
        send_spaced(make_request(0, 5, CLS_MEM, BLK_PROLOGUE, 4'b0001, 4, 0, 0, 0));
        send_spaced(make_request(0, 6, CLS_BRANCH, BLK_PROLOGUE, 4'b1111, 4, 5, 200, 3));
        send_spaced(make_request(0, 7, CLS_ALU, BLK_PROLOGUE, 4'b0000, 5, 5, 5, 5));
        send_spaced(make_request(0, 8, CLS_ALU, BLK_SPARE, 4'b0001, 6, 0, 0, 0));
        send_spaced(make_request(0, 9, CLS_ALU, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 10, CLS_ALU, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 11, CLS_ALU, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 12, CLS_MUL, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 13, CLS_MEM, BLK_LOOP, 4'b0001, 12, 0, 0, 0));
        send_spaced(make_request(0, 14, CLS_BRANCH, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_spaced(make_request(0, 15, CLS_ALU, BLK_EPILOGUE, 4'b0001, 11, 0, 0, 0));
        send_spaced(make_request(0, 0, CLS_MUL, BLK_EPILOGUE, 4'b0001, 6, 0, 0, 0));
        send_spaced(make_request(0, 16, CLS_ALU, BLK_EPILOGUE, 4'b0001, 0, 0, 0, 0));
        send_spaced(make_request(0, 255, CLS_MUL, BLK_EPILOGUE, 4'b1111,
                                 255, 255, 255, 255));
        // A zero interval behaves as one, and the loop rows filled above are still held.
        write_interval(0);
        send_request(make_request(0, 20, CLS_ALU, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_request(make_request(0, 21, CLS_BRANCH, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        write_interval((1 << II_W) - 1);
        send_request(make_request(1, 22, CLS_ALU, BLK_LOOP, 4'b0000, 0, 0, 0, 0));
        send_request(make_request(0, 23, CLS_ALU, BLK_LOOP, 4'b0001, 22, 0, 0, 0));
        send_request(make_request(0, 255, CLS_BRANCH, BLK_SPARE, 4'b1111, 22, 23, 0, 255));
        write_interval(MAX_II);
    endtask

    task automatic run_program(input int kind);
        int              n;
        int              pro_len;
        int              loop_len;
        int              link;
        int              id;
        bit              sp;
        logic [ID_W-1:0] base;
        logic [1:0]      blk;
        logic [1:0]      cls;
        logic [3:0]      valid;
        int              d [NUM_DEPS];
        quiet_stretch = ($urandom_range(0, 3) == 0);
        base = ID_W'($urandom_range(0, MAX_INSTR - 1));
        case (kind)
            PROG_CHAIN: n = $urandom_range(190, 200);
            PROG_NOISE: n = $urandom_range(5, 20);
            default:    n = $urandom_range(4, 40);
        endcase
        pro_len  = $urandom_range(0, n / 3);
        loop_len = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            id  = (int'(base) + i) % MAX_INSTR;
            sp  = (i == 0);
            cls = 2'($urandom_range(0, 3));
            for (int k = 0; k < NUM_DEPS; k++) begin
                valid[k] = ($urandom_range(0, 9) < 6);
                d[k] = earlier_id(base, i);
            end
            case (kind)
                PROG_CHAIN: begin
                    // Mostly multiplies, each tied to the one before, so that the
                    // ready times climb past the end of the bundle table.
                    if ($urandom_range(0, 19) != 0) cls = CLS_MUL;
                    case ($urandom_range(0, 2))
                        0:       blk = BLK_PROLOGUE;
                        1:       blk = BLK_EPILOGUE;
                        default: blk = BLK_SPARE;
                    endcase
                    link = $urandom_range(0, NUM_DEPS - 1);
                    if (i > 0) begin
                        valid[link] = 1'b1;
                        d[link] = (id + MAX_INSTR - 1) % MAX_INSTR;
                    end
                end
                PROG_NOISE: begin
                    sp    = ($urandom_range(0, 9) == 0);
                    id    = $urandom_range(0, MAX_INSTR - 1);
                    blk   = 2'($urandom_range(0, 3));
                    valid = 4'($urandom_range(0, 15));
                    for (int k = 0; k < NUM_DEPS; k++) d[k] = $urandom_range(0, MAX_INSTR - 1);
                end
                default: begin
                    if (i < pro_len) blk = BLK_PROLOGUE;
                    else if (i < pro_len + loop_len) blk = BLK_LOOP;
                    else blk = BLK_EPILOGUE;
                    if ($urandom_range(0, 19) == 0) blk = 2'($urandom_range(0, 3));
                end
            endcase
            send_request(make_request(sp, id, cls, blk, valid, d[0], d[1], d[2], d[3]));
            hold_off();
        end
    endtask

    initial begin
        int unsigned roll;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_program(PROG_CHAIN);
        while (requests_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) write_interval(pick_interval());
            roll = $urandom_range(0, 99);
            if (roll < 5) run_program(PROG_CHAIN);
            else if (roll < 25) run_program(PROG_NOISE);
            else run_program(PROG_WELL);
        end
        wait_idle();
        repeat (END_WAIT) @(posedge i_clk);
        if (sched_sb.error_count == 0 && sched_sb.expected_issues.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
